### hw/rtl/heartbeat_watchdog_supervisor_unit_assert.svh
// heartbeat_watchdog_supervisor_unit_assert.svh: assertion macros for the supervisor RTL.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef HEARTBEAT_WATCHDOG_SUPERVISOR_UNIT_ASSERT_SVH
`define HEARTBEAT_WATCHDOG_SUPERVISOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define HWS_AST_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hws: assertion failed");

// Next-cycle implication, checked outside reset.
`define HWS_AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hws: assertion failed");

`endif

### hw/rtl/hws_pkg.sv
`timescale 1ns / 1ps
// hws_pkg.sv: opcodes, register indexes, reset values, types and the timeout table
// of the heartbeat watchdog supervisor. No dependencies.
package hws_pkg;

  localparam int MASK_W      = 6;
  localparam int TMO_ENTRIES = 6;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [2:0] OP_TICK      = 3'd0;
  localparam logic [2:0] OP_HEARTBEAT = 3'd1;
  localparam logic [2:0] OP_COUNT     = 3'd2;
  localparam logic [2:0] OP_COLLECT   = 3'd3;
  localparam logic [2:0] OP_REFRESH   = 3'd4;
  localparam logic [2:0] OP_CLEAR     = 3'd5;
  localparam logic [2:0] OP_FATAL     = 3'd6;
  localparam logic [2:0] OP_READ      = 3'd7;

  localparam logic [CFG_IDX_W-1:0] CFG_TICK_PERIOD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_GRACE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXEMPT_TASK   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WATCHDOG_ON   = 2'd3;

  localparam logic [9:0]  RST_TICK_PERIOD = 10'd1;
  localparam logic [15:0] RST_GRACE       = 16'd3000;
  localparam logic [2:0]  RST_EXEMPT      = 3'd5;
  localparam logic        RST_WD_ON       = 1'b0;

  typedef struct packed {
    logic [9:0]  tick_period_ms;
    logic [15:0] startup_grace_ms;
    logic [2:0]  exempt_task;
    logic        watchdog_on;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UPT,
    S_EXEC,
    S_MOD,
    S_RAGE,
    S_CRD,
    S_CDIF,
    S_CMUL,
    S_CCMP,
    S_DONE
  } state_t;

  localparam logic [10:0] TMO_TBL [TMO_ENTRIES] = '{
    11'd1000, 11'd1000, 11'd1500, 11'd2000, 11'd1500, 11'd2000
  };

  // Tasks beyond the table share the last entry.
  function automatic logic [10:0] task_timeout(input logic [2:0] t);
    logic [10:0] v;
    if (32'(t) < TMO_ENTRIES) begin
      v = TMO_TBL[t];
    end else begin
      v = TMO_TBL[TMO_ENTRIES-1];
    end
    return v;
  endfunction

endpackage

### hw/rtl/hws_vmem.sv
`timescale 1ns / 1ps
// hws_vmem.sv: single-port-write, single-port-read synchronous memory with per-entry
// valid bits; an entry never written since reset or clear reads as zero. No dependencies.
module hws_vmem #(
  parameter int DEPTH = 6,
  parameter int WIDTH = 32,
  parameter int AW    = 3
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clr_all,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [DEPTH-1:0] valid_r, valid_nxt;
  logic [WIDTH-1:0] rd_q_r;
  logic             rd_v_r;

  always_comb begin
    valid_nxt = valid_r;
    if (clr_all) begin
      valid_nxt = '0;
    end else if (wr_en) begin
      valid_nxt[wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= store_r[rd_addr];
      rd_v_r <= valid_r[rd_addr];
    end
  end

  assign rd_data = rd_v_r ? rd_q_r : '0;

endmodule

### hw/rtl/hws_ctrl.sv
`timescale 1ns / 1ps
`include "heartbeat_watchdog_supervisor_unit_assert.svh"
// hws_ctrl.sv: sequencer and datapath of the supervisor: opcode decode, stamp walk, shared
// tick-to-ms multiplier and result registers. Depends on hws_pkg and the assertion header.
module hws_ctrl
  import hws_pkg::*;
#(
  parameter int NUM_TASKS    = 6,
  parameter int NUM_COUNTERS = 10,
  parameter int TAW          = 3,
  parameter int CAW          = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  cfg_t            cfg,
  input  logic            start,
  output logic            busy,
  input  logic [2:0]      in_opcode,
  input  logic [2:0]      in_task_index,
  input  logic [3:0]      in_event_index,
  input  logic [3:0]      in_fatal_code,
  output logic            out_valid,
  output logic            out_healthy,
  output logic [5:0]      out_stall_mask,
  output logic            out_refresh_granted,
  output logic [31:0]     out_counter_value,
  output logic [31:0]     out_beat_age,
  output logic [31:0]     out_elapsed_ms,
  output logic [3:0]      out_fatal_now,
  output logic            st_wr_en,
  output logic [TAW-1:0]  st_wr_addr,
  output logic [31:0]     st_wr_data,
  output logic            st_rd_en,
  output logic [TAW-1:0]  st_rd_addr,
  input  logic [31:0]     st_rd_data,
  output logic            cn_clr,
  output logic            cn_wr_en,
  output logic [CAW-1:0]  cn_wr_addr,
  output logic [31:0]     cn_wr_data,
  output logic            cn_rd_en,
  output logic [CAW-1:0]  cn_rd_addr,
  input  logic [31:0]     cn_rd_data
);

  localparam int NCHK = (NUM_TASKS < MASK_W) ? NUM_TASKS : MASK_W;
  localparam logic [2:0]     LAST_T      = 3'(NCHK - 1);
  localparam logic [CAW-1:0] IDX_REFRESH = CAW'(NUM_COUNTERS - 2);
  localparam logic [CAW-1:0] IDX_SKIP    = CAW'(NUM_COUNTERS - 1);

  state_t state_r, state_nxt;

  logic [2:0]        op_r, op_nxt;
  logic [2:0]        task_r, task_nxt;
  logic [3:0]        ev_r, ev_nxt;
  logic [3:0]        code_r, code_nxt;
  logic [31:0]       tick_r, tick_nxt;
  logic [31:0]       uptime_r, uptime_nxt;
  logic [31:0]       diff_r, diff_nxt;
  logic              zero_r, zero_nxt;
  logic [31:0]       prod_r, prod_nxt;
  logic              grace_ok_r, grace_ok_nxt;
  logic [31:0]       cval_r, cval_nxt;
  logic [2:0]        t_r, t_nxt;
  logic [MASK_W-1:0] mask_acc_r, mask_acc_nxt;
  logic [MASK_W-1:0] stalled_r, stalled_nxt;
  logic [3:0]        fatal_r, fatal_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_healthy_r, out_healthy_nxt;
  logic [MASK_W-1:0] out_mask_r, out_mask_nxt;
  logic              out_granted_r, out_granted_nxt;
  logic [31:0]       out_cval_r, out_cval_nxt;
  logic [31:0]       out_age_r, out_age_nxt;
  logic [31:0]       out_uptime_r, out_uptime_nxt;
  logic [3:0]        out_fatal_r, out_fatal_nxt;

  logic              task_ok, ev_cnt_ok, ev_rd_ok, grant_now, stall_now;
  logic [31:0]       mul_a;
  logic [41:0]       mul_full;
  logic [10:0]       tmo;
  logic [MASK_W-1:0] mask_upd;
  logic [CAW-1:0]    cnt_addr;

  assign task_ok   = 32'(task_r) < NUM_TASKS;
  assign ev_cnt_ok = (32'(ev_r) + 32'd2) < NUM_COUNTERS;
  assign ev_rd_ok  = 32'(ev_r) < NUM_COUNTERS;
  assign grant_now = (stalled_r == '0) && (fatal_r == '0);

  // One 32x10 multiplier converts ticks to ms for both uptime and heartbeat ages.
  assign mul_a    = (state_r == S_UPT) ? tick_r : diff_r;
  assign mul_full = mul_a * cfg.tick_period_ms;

  assign tmo       = task_timeout(t_r);
  assign stall_now = (t_r != cfg.exempt_task) && grace_ok_r &&
                     (zero_r || (prod_r > 32'(tmo)));

  always_comb begin
    mask_upd      = mask_acc_r;
    mask_upd[t_r] = stall_now;
  end

  // A refresh bumps the refresh counter (granted, watchdog on) or the skip counter
  // (not granted); stalled and fatal state cannot change in flight, so grant_now is stable.
  always_comb begin
    if (op_r == OP_REFRESH) begin
      cnt_addr = grant_now ? IDX_REFRESH : IDX_SKIP;
    end else begin
      cnt_addr = CAW'(ev_r);
    end
  end

  assign cn_rd_addr = cnt_addr;
  assign cn_wr_addr = cnt_addr;
  assign cn_wr_data = cn_rd_data + 32'd1;
  assign st_wr_addr = TAW'(task_r);
  assign st_wr_data = tick_r;
  assign st_rd_addr = (state_r == S_CRD) ? TAW'(t_r) : TAW'(task_r);

  always_comb begin
    state_nxt       = state_r;
    op_nxt          = op_r;
    task_nxt        = task_r;
    ev_nxt          = ev_r;
    code_nxt        = code_r;
    tick_nxt        = tick_r;
    uptime_nxt      = uptime_r;
    diff_nxt        = diff_r;
    zero_nxt        = zero_r;
    prod_nxt        = prod_r;
    grace_ok_nxt    = grace_ok_r;
    cval_nxt        = cval_r;
    t_nxt           = t_r;
    mask_acc_nxt    = mask_acc_r;
    stalled_nxt     = stalled_r;
    fatal_nxt       = fatal_r;
    out_valid_nxt   = 1'b0;
    out_healthy_nxt = out_healthy_r;
    out_mask_nxt    = out_mask_r;
    out_granted_nxt = out_granted_r;
    out_cval_nxt    = out_cval_r;
    out_age_nxt     = out_age_r;
    out_uptime_nxt  = out_uptime_r;
    out_fatal_nxt   = out_fatal_r;
    st_wr_en        = 1'b0;
    st_rd_en        = 1'b0;
    cn_clr          = 1'b0;
    cn_wr_en        = 1'b0;
    cn_rd_en        = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt    = in_opcode;
          task_nxt  = in_task_index;
          ev_nxt    = in_event_index;
          code_nxt  = in_fatal_code;
          state_nxt = S_UPT;
        end
      end
      S_UPT: begin
        uptime_nxt = mul_full[31:0];
        state_nxt  = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        case (op_r)
          OP_TICK: begin
            tick_nxt   = tick_r + 32'd1;
            uptime_nxt = uptime_r + 32'(cfg.tick_period_ms);
          end
          OP_HEARTBEAT: begin
            st_wr_en = task_ok;
          end
          OP_COUNT: begin
            if (ev_cnt_ok) begin
              cn_rd_en  = 1'b1;
              state_nxt = S_MOD;
            end
          end
          OP_COLLECT: begin
            grace_ok_nxt = uptime_r > 32'(cfg.startup_grace_ms);
            mask_acc_nxt = '0;
            t_nxt        = '0;
            state_nxt    = S_CRD;
          end
          OP_REFRESH: begin
            if (!grant_now || cfg.watchdog_on) begin
              cn_rd_en  = 1'b1;
              state_nxt = S_MOD;
            end
          end
          OP_CLEAR: begin
            cn_clr = 1'b1;
          end
          OP_FATAL: begin
            fatal_nxt = code_r;
          end
          OP_READ: begin
            cn_rd_en  = ev_rd_ok;
            st_rd_en  = task_ok;
            state_nxt = S_MOD;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_MOD: begin
        if (op_r == OP_READ) begin
          cval_nxt  = ev_rd_ok ? cn_rd_data : 32'd0;
          diff_nxt  = tick_r - st_rd_data;
          state_nxt = S_RAGE;
        end else begin
          cn_wr_en  = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_RAGE: begin
        prod_nxt  = mul_full[31:0];
        state_nxt = S_DONE;
      end
      S_CRD: begin
        st_rd_en  = 1'b1;
        state_nxt = S_CDIF;
      end
      S_CDIF: begin
        diff_nxt  = tick_r - st_rd_data;
        zero_nxt  = (st_rd_data == 32'd0);
        state_nxt = S_CMUL;
      end
      S_CMUL: begin
        prod_nxt  = mul_full[31:0];
        state_nxt = S_CCMP;
      end
      S_CCMP: begin
        mask_acc_nxt = mask_upd;
        if (t_r == LAST_T) begin
          stalled_nxt = mask_upd;
          state_nxt   = S_DONE;
        end else begin
          t_nxt     = t_r + 3'd1;
          state_nxt = S_CRD;
        end
      end
      S_DONE: begin
        out_valid_nxt   = 1'b1;
        out_healthy_nxt = grant_now;
        out_mask_nxt    = stalled_r;
        out_granted_nxt = (op_r == OP_REFRESH) && grant_now;
        out_cval_nxt    = (op_r == OP_READ) ? cval_r : 32'd0;
        out_age_nxt     = ((op_r == OP_READ) && task_ok) ? prod_r : 32'd0;
        out_uptime_nxt  = uptime_r;
        out_fatal_nxt   = fatal_r;
        state_nxt       = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tick_r      <= '0;
      stalled_r   <= '0;
      fatal_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tick_r      <= tick_nxt;
      stalled_r   <= stalled_nxt;
      fatal_r     <= fatal_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    task_r        <= task_nxt;
    ev_r          <= ev_nxt;
    code_r        <= code_nxt;
    uptime_r      <= uptime_nxt;
    diff_r        <= diff_nxt;
    zero_r        <= zero_nxt;
    prod_r        <= prod_nxt;
    grace_ok_r    <= grace_ok_nxt;
    cval_r        <= cval_nxt;
    t_r           <= t_nxt;
    mask_acc_r    <= mask_acc_nxt;
    out_healthy_r <= out_healthy_nxt;
    out_mask_r    <= out_mask_nxt;
    out_granted_r <= out_granted_nxt;
    out_cval_r    <= out_cval_nxt;
    out_age_r     <= out_age_nxt;
    out_uptime_r  <= out_uptime_nxt;
    out_fatal_r   <= out_fatal_nxt;
  end

  assign busy                = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_healthy         = out_healthy_r;
  assign out_stall_mask      = out_mask_r;
  assign out_refresh_granted = out_granted_r;
  assign out_counter_value   = out_cval_r;
  assign out_beat_age        = out_age_r;
  assign out_elapsed_ms      = out_uptime_r;
  assign out_fatal_now       = out_fatal_r;

  `HWS_AST_IMP(a_strobe_idle, out_valid_r, state_r == S_IDLE)
  `HWS_AST_NXT(a_accept_starts, start && (state_r == S_IDLE), state_r == S_UPT)
  `HWS_AST_NXT(a_done_strobes, state_r == S_DONE, out_valid_r)
  `HWS_AST_IMP(a_healthy_match, out_valid_r, out_healthy_r == ((out_mask_r == '0) && (out_fatal_r == '0)))
  `HWS_AST_IMP(a_walk_range, state_r == S_CCMP, 32'(t_r) < NCHK)

endmodule

### hw/rtl/heartbeat_watchdog_supervisor_unit.sv
`timescale 1ns / 1ps
// heartbeat_watchdog_supervisor_unit.sv: top level; configuration registers, stamp and
// counter memories, sequencer. Depends on hws_pkg, hws_vmem and hws_ctrl.
//
//   Channel   Ports                          Handshake
//   input     in_opcode .. in_fatal_code     transfer when start high and busy low
//   result    out_healthy .. out_fatal_now   out_valid high for one cycle, no stall
//   config    cfg_we, cfg_index, cfg_wdata   write when cfg_we high, no wait
//
// Tick, heartbeat, clear, fatal, an ignored count and an uncounted refresh pass the states
// UPT, EXEC and DONE; a counter read-modify-write adds MOD, a read adds MOD and RAGE, and
// collect walks N = min(NUM_TASKS, 6) stamps between EXEC and DONE, each passing read,
// subtract, multiply and compare on the one shared multiplier. The result strobes in the
// cycle busy drops, and a new item may be taken in that same cycle. The receiver cannot stall.
// Reset is synchronous; memory contents need no clearing pass (valid bits per entry).
module heartbeat_watchdog_supervisor_unit
  import hws_pkg::*;
#(
  parameter int NUM_TASKS    = 6,
  parameter int NUM_COUNTERS = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [2:0]            in_opcode,
  input  logic [2:0]            in_task_index,
  input  logic [3:0]            in_event_index,
  input  logic [3:0]            in_fatal_code,
  output logic                  out_valid,
  output logic                  out_healthy,
  output logic [5:0]            out_stall_mask,
  output logic                  out_refresh_granted,
  output logic [31:0]           out_counter_value,
  output logic [31:0]           out_beat_age,
  output logic [31:0]           out_elapsed_ms,
  output logic [3:0]            out_fatal_now,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int TAW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int CAW = $clog2(NUM_COUNTERS);

  cfg_t cfg_r, cfg_nxt;

  logic           st_wr_en, st_rd_en;
  logic [TAW-1:0] st_wr_addr, st_rd_addr;
  logic [31:0]    st_wr_data, st_rd_data;
  logic           cn_clr, cn_wr_en, cn_rd_en;
  logic [CAW-1:0] cn_wr_addr, cn_rd_addr;
  logic [31:0]    cn_wr_data, cn_rd_data;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_TICK_PERIOD:   cfg_nxt.tick_period_ms   = cfg_wdata[9:0];
        CFG_STARTUP_GRACE: cfg_nxt.startup_grace_ms = cfg_wdata[15:0];
        CFG_EXEMPT_TASK:   cfg_nxt.exempt_task      = cfg_wdata[2:0];
        CFG_WATCHDOG_ON:   cfg_nxt.watchdog_on      = cfg_wdata[0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tick_period_ms   <= RST_TICK_PERIOD;
      cfg_r.startup_grace_ms <= RST_GRACE;
      cfg_r.exempt_task      <= RST_EXEMPT;
      cfg_r.watchdog_on      <= RST_WD_ON;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  hws_vmem #(
    .DEPTH(NUM_TASKS),
    .WIDTH(32),
    .AW   (TAW)
  ) u_stamps (
    .clk    (clk),
    .rst_n  (rst_n),
    .clr_all(1'b0),
    .wr_en  (st_wr_en),
    .wr_addr(st_wr_addr),
    .wr_data(st_wr_data),
    .rd_en  (st_rd_en),
    .rd_addr(st_rd_addr),
    .rd_data(st_rd_data)
  );

  hws_vmem #(
    .DEPTH(NUM_COUNTERS),
    .WIDTH(32),
    .AW   (CAW)
  ) u_counters (
    .clk    (clk),
    .rst_n  (rst_n),
    .clr_all(cn_clr),
    .wr_en  (cn_wr_en),
    .wr_addr(cn_wr_addr),
    .wr_data(cn_wr_data),
    .rd_en  (cn_rd_en),
    .rd_addr(cn_rd_addr),
    .rd_data(cn_rd_data)
  );

  hws_ctrl #(
    .NUM_TASKS   (NUM_TASKS),
    .NUM_COUNTERS(NUM_COUNTERS),
    .TAW         (TAW),
    .CAW         (CAW)
  ) u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .start              (start),
    .busy               (busy),
    .in_opcode          (in_opcode),
    .in_task_index      (in_task_index),
    .in_event_index     (in_event_index),
    .in_fatal_code      (in_fatal_code),
    .out_valid          (out_valid),
    .out_healthy        (out_healthy),
    .out_stall_mask     (out_stall_mask),
    .out_refresh_granted(out_refresh_granted),
    .out_counter_value  (out_counter_value),
    .out_beat_age       (out_beat_age),
    .out_elapsed_ms     (out_elapsed_ms),
    .out_fatal_now      (out_fatal_now),
    .st_wr_en           (st_wr_en),
    .st_wr_addr         (st_wr_addr),
    .st_wr_data         (st_wr_data),
    .st_rd_en           (st_rd_en),
    .st_rd_addr         (st_rd_addr),
    .st_rd_data         (st_rd_data),
    .cn_clr             (cn_clr),
    .cn_wr_en           (cn_wr_en),
    .cn_wr_addr         (cn_wr_addr),
    .cn_wr_data         (cn_wr_data),
    .cn_rd_en           (cn_rd_en),
    .cn_rd_addr         (cn_rd_addr),
    .cn_rd_data         (cn_rd_data)
  );

endmodule
